// ----- sv/swd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pkg: shared types and constants of the single-wire dimming transmitter
// Transfer payloads, register indexes, reset values and the waveform phases.
// ----------------------------------------------------------------------------
package swd_pkg;

  // Field widths fixed by the interface
  localparam int unsigned LEVEL_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Input transfer: one tick or one brightness command
  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] level;
  } in_t;

  // Output transfer: one per input transfer
  typedef struct packed {
    logic pin;
    logic busy_res;
    logic rejected;
  } out_t;

  // Input kind codes
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT     = 3'd0,
    REG_LONG      = 3'd1,
    REG_MODE_HIGH = 3'd2,
    REG_MODE_LOW  = 3'd3,
    REG_SETTLE    = 3'd4,
    REG_ADDRESS   = 3'd5
  } reg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic [7:0]  short_time;
    logic [7:0]  long_time;
    logic [9:0]  mode_high_time;
    logic [9:0]  mode_low_time;
    logic [15:0] settle_time;
    logic [7:0]  device_address;
  } cfg_t;

  localparam logic [7:0]  RST_SHORT     = 8'd2;
  localparam logic [7:0]  RST_LONG      = 8'd4;
  localparam logic [9:0]  RST_MODE_HIGH = 10'd120;
  localparam logic [9:0]  RST_MODE_LOW  = 10'd280;
  localparam logic [15:0] RST_SETTLE    = 16'd1000;
  localparam logic [7:0]  RST_ADDRESS   = 8'h72;

  // Operation classes handed from the front end to the sequencer
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_OFF  = 2'd1,
    OP_ON   = 2'd2
  } op_e;

  // Waveform phases
  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_OFF_SETTLE  = 4'd1,
    PH_MODE_HIGH   = 4'd2,
    PH_MODE_LOW    = 4'd3,
    PH_MODE_SETTLE = 4'd4,
    PH_START_A     = 4'd5,
    PH_ADDR_LOW    = 4'd6,
    PH_ADDR_HIGH   = 4'd7,
    PH_EOS_A       = 4'd8,
    PH_EOS_B       = 4'd9,
    PH_START_B     = 4'd10,
    PH_DATA_LOW    = 4'd11,
    PH_DATA_HIGH   = 4'd12,
    PH_EOS_C       = 4'd13,
    PH_FINAL       = 4'd14
  } phase_e;

  // Pin level driven during a phase
  function automatic logic seg_pin(phase_e p);
    logic v;
    case (p)
      PH_MODE_HIGH, PH_MODE_SETTLE, PH_START_A, PH_ADDR_HIGH,
      PH_START_B, PH_DATA_HIGH, PH_FINAL: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/swd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swd_front: input classifier and two-entry queue
// Sorts each input transfer into tick, off or on and queues it for the
// sequencer, so the input side keeps flowing while the sequencer waits.
// ----------------------------------------------------------------------------
module swd_front import swd_pkg::*; #(
  parameter int unsigned LEVEL_BITS = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_i,
  output logic                       q_valid_o,
  output op_e                        q_op_o,
  output logic [LEVEL_BITS-1:0]      q_level_o,
  input  wire logic                  q_pop_i
);

  localparam int unsigned DEPTH = 2;

  op_e                   op_mem_q  [DEPTH];
  logic [LEVEL_BITS-1:0] lvl_mem_q [DEPTH];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;

  logic                  push;
  logic                  pop;
  logic [LEVEL_BITS-1:0] level_m;
  op_e                   op_c;

  // Classify: only the low LEVEL_BITS of the level count, also for off
  always_comb begin
    level_m = LEVEL_BITS'(in_i.level);
    if (in_i.kind == KIND_LEVEL) begin
      op_c = (level_m == '0) ? OP_OFF : OP_ON;
    end else begin
      op_c = OP_TICK;
    end
  end

  assign in_stall_o = (count_q == 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_op_o     = op_mem_q[rd_ptr_q];
  assign q_level_o  = lvl_mem_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = q_pop_i && q_valid_o;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem_q[wr_ptr_q]  <= op_c;
      lvl_mem_q[wr_ptr_q] <= level_m;
    end
  end

  // A queued item stays until the sequencer takes it
  a_hold_until_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o && !q_pop_i |=> q_valid_o)
    else $error("queued item lost without a pop");

endmodule
`default_nettype wire

// ----- sv/swd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swd_back: waveform sequencer with output register
// Applies queued ticks and commands to the phase, bit and timer state, walks
// over zero-length segments one per unstalled cycle, registers one result per item.
// ----------------------------------------------------------------------------
module swd_back import swd_pkg::*; #(
  parameter int unsigned LEVEL_BITS = 5,
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  q_valid_i,
  input  wire op_e                   q_op_i,
  input  wire logic [LEVEL_BITS-1:0] q_level_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_o
);

  // Bit shifter holds the address, or three zero bits and the level
  localparam int unsigned SRW = (LEVEL_BITS + 3 > 8) ? LEVEL_BITS + 3 : 8;
  localparam int unsigned BIW = $clog2(SRW);
  localparam logic [BIW-1:0] ADDR_LAST = BIW'(7);
  localparam logic [BIW-1:0] DATA_LAST = BIW'(LEVEL_BITS + 2);

  typedef struct packed {
    phase_e           phase;
    logic [BIW-1:0]   bit_idx;
    logic [SRW-1:0]   sr;
  } cursor_t;

  // Next segment of the waveform
  function automatic cursor_t advance(cursor_t c, logic [7:0] addr,
                                      logic [LEVEL_BITS-1:0] held);
    cursor_t n;
    n = c;
    case (c.phase)
      PH_MODE_HIGH:   n.phase = PH_MODE_LOW;
      PH_MODE_LOW:    n.phase = PH_MODE_SETTLE;
      PH_MODE_SETTLE: n.phase = PH_START_A;
      PH_START_A: begin
        n.phase   = PH_ADDR_LOW;
        n.bit_idx = '0;
        n.sr      = SRW'(addr) << (SRW - 8);
      end
      PH_ADDR_LOW:    n.phase = PH_ADDR_HIGH;
      PH_ADDR_HIGH: begin
        if (c.bit_idx >= ADDR_LAST) begin
          n.phase = PH_EOS_A;
        end else begin
          n.phase   = PH_ADDR_LOW;
          n.bit_idx = c.bit_idx + BIW'(1);
          n.sr      = c.sr << 1;
        end
      end
      PH_EOS_A:       n.phase = PH_EOS_B;
      PH_EOS_B:       n.phase = PH_START_B;
      PH_START_B: begin
        n.phase   = PH_DATA_LOW;
        n.bit_idx = '0;
        n.sr      = SRW'(held) << (SRW - LEVEL_BITS - 3);
      end
      PH_DATA_LOW:    n.phase = PH_DATA_HIGH;
      PH_DATA_HIGH: begin
        if (c.bit_idx >= DATA_LAST) begin
          n.phase = PH_EOS_C;
        end else begin
          n.phase   = PH_DATA_LOW;
          n.bit_idx = c.bit_idx + BIW'(1);
          n.sr      = c.sr << 1;
        end
      end
      PH_EOS_C:       n.phase = PH_FINAL;
      default:        n.phase = PH_IDLE;
    endcase
    return n;
  endfunction

  // Length of the segment in ticks
  function automatic logic [15:0] seg_len(cursor_t c, cfg_t cfg);
    logic        b;
    logic [15:0] v;
    b = c.sr[SRW-1];
    case (c.phase)
      PH_OFF_SETTLE, PH_MODE_SETTLE, PH_FINAL: v = cfg.settle_time;
      PH_MODE_HIGH: v = {6'd0, cfg.mode_high_time};
      PH_MODE_LOW:  v = {6'd0, cfg.mode_low_time};
      PH_ADDR_LOW, PH_DATA_LOW:
        v = {8'd0, (b ? cfg.short_time : cfg.long_time)};
      PH_ADDR_HIGH, PH_DATA_HIGH:
        v = {8'd0, (b ? cfg.long_time : cfg.short_time)};
      default:      v = {8'd0, cfg.long_time};
    endcase
    return v;
  endfunction

  cursor_t               cur_q, cur_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic                  needs_q, needs_d;
  logic [LEVEL_BITS-1:0] held_q, held_d;
  logic                  pin_q, pin_d;
  logic                  seek_q, seek_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  out_free;
  logic                  eval;
  logic                  done;
  logic                  rej;
  cursor_t               cand;
  cursor_t               nxt;
  logic [TIMER_BITS-1:0] len;
  logic [TIMER_BITS-1:0] timer_dec;
  logic [LEVEL_BITS-1:0] held_eff;

  assign out_free = !out_valid_q || !out_stall_i;

  // Apply one item, then load the segment or step over an empty one
  always_comb begin
    cur_d       = cur_q;
    timer_d     = timer_q;
    needs_d     = needs_q;
    held_d      = held_q;
    pin_d       = pin_q;
    seek_d      = seek_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    eval        = 1'b0;
    done        = 1'b0;
    rej         = 1'b0;
    cand        = cur_q;
    nxt         = cur_q;
    len         = '0;
    held_eff    = held_q;
    timer_dec   = timer_q - TIMER_BITS'(1);

    if (out_free) begin
      if (seek_q) begin
        eval = 1'b1;
      end else if (q_valid_i) begin
        q_pop_o = 1'b1;
        case (q_op_i)
          OP_TICK: begin
            if (cur_q.phase == PH_IDLE) begin
              done = 1'b1;
            end else if (timer_dec == '0) begin
              cand = advance(cur_q, cfg_i.device_address, held_q);
              eval = 1'b1;
            end else begin
              timer_d = timer_dec;
              done    = 1'b1;
            end
          end
          OP_OFF, OP_ON: begin
            if (cur_q.phase != PH_IDLE) begin
              rej  = 1'b1;
              done = 1'b1;
            end else if (q_op_i == OP_OFF) begin
              needs_d      = 1'b1;
              cand.phase   = PH_OFF_SETTLE;
              cand.bit_idx = '0;
              eval         = 1'b1;
            end else begin
              held_d       = q_level_i;
              held_eff     = q_level_i;
              needs_d      = 1'b0;
              cand.phase   = needs_q ? PH_MODE_HIGH : PH_START_A;
              cand.bit_idx = '0;
              eval         = 1'b1;
            end
          end
          default: done = 1'b1;
        endcase
      end
    end

    // Segment load
    if (eval) begin
      if (cand.phase == PH_IDLE) begin
        cur_d   = cand;
        timer_d = '0;
        seek_d  = 1'b0;
        done    = 1'b1;
      end else begin
        pin_d = seg_pin(cand.phase);
        len   = TIMER_BITS'(seg_len(cand, cfg_i));
        if (len != '0) begin
          cur_d   = cand;
          timer_d = len;
          seek_d  = 1'b0;
          done    = 1'b1;
        end else begin
          nxt   = advance(cand, cfg_i.device_address, held_eff);
          cur_d = nxt;
          if (nxt.phase == PH_IDLE) begin
            timer_d = '0;
            seek_d  = 1'b0;
            done    = 1'b1;
          end else begin
            seek_d = 1'b1;
          end
        end
      end
    end

    // Output register
    if (out_free) begin
      out_valid_d = done;
    end
    if (done) begin
      out_d.pin      = pin_d;
      out_d.busy_res = (cur_d.phase != PH_IDLE);
      out_d.rejected = rej;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '{phase: PH_IDLE, bit_idx: '0, sr: '0};
      timer_q     <= '0;
      needs_q     <= 1'b0;
      held_q      <= '0;
      pin_q       <= 1'b0;
      seek_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      timer_q     <= timer_d;
      needs_q     <= needs_d;
      held_q      <= held_d;
      pin_q       <= pin_d;
      seek_q      <= seek_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Segment walk never parks on idle
  a_seek_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seek_q |-> cur_q.phase != PH_IDLE)
    else $error("segment walk pending in idle phase");

  // A loaded segment always has ticks left
  a_timer_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seek_q && cur_q.phase != PH_IDLE |-> timer_q != '0)
    else $error("active segment with empty timer");

  // A dropped command is only reported while a sequence runs
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res)
    else $error("rejected result without busy");

endmodule
`default_nettype wire

// ----- sv/single_wire_dimming_tx.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// single_wire_dimming_tx: single-wire dimming pin transmitter
// Input transfers carry ticks or brightness commands; each input transfer
// gives one output transfer with the pin level, busy and rejected flags.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. Configuration is a plain write port (enable, index, data).
// Results are registered; the sequencer steps over each zero-length segment
// (a register written to 0) before it takes the next item from the queue.
// Throughput: one item per cycle while the output is not stalled and no
// segment walk is pending; a two-entry queue sits in front of the sequencer.
// Reset: phase idle, pin low, registers at their defaults, queue empty.
// When the output is stalled the result holds in the output register, the
// sequencer pauses and the queue fills; input stall rises when it is full.
// ----------------------------------------------------------------------------
module single_wire_dimming_tx import swd_pkg::*; #(
  parameter int unsigned LEVEL_BITS = 5,
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                  cfg_q, cfg_d;
  logic                  q_valid;
  op_e                   q_op;
  logic [LEVEL_BITS-1:0] q_level;
  logic                  q_pop;

  // Configuration registers; writes to unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SHORT:     cfg_d.short_time     = cfg_data_i[7:0];
        REG_LONG:      cfg_d.long_time      = cfg_data_i[7:0];
        REG_MODE_HIGH: cfg_d.mode_high_time = cfg_data_i[9:0];
        REG_MODE_LOW:  cfg_d.mode_low_time  = cfg_data_i[9:0];
        REG_SETTLE:    cfg_d.settle_time    = cfg_data_i[15:0];
        REG_ADDRESS:   cfg_d.device_address = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{short_time:     RST_SHORT,
                 long_time:      RST_LONG,
                 mode_high_time: RST_MODE_HIGH,
                 mode_low_time:  RST_MODE_LOW,
                 settle_time:    RST_SETTLE,
                 device_address: RST_ADDRESS};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Classifier and queue
  swd_front #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_valid_o  (q_valid),
    .q_op_o     (q_op),
    .q_level_o  (q_level),
    .q_pop_i    (q_pop)
  );

  // Waveform sequencer
  swd_back #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_level_i   (q_level),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ----- verif/tb_single_wire_dimming_tx.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_wire_dimming_tx: self-checking bench of the dimming transmitter
// Ticks and brightness commands go in over valid/stall. A scoreboard follows
// the waveform phase by phase and checks the pin, busy and rejected flags of
// every output transfer. Register sets run from all-zero segments to the
// longest the registers allow, under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_single_wire_dimming_tx;
  import swd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Waveform tracker and store of pending line states
  class dimming_scoreboard;
    cfg_t              regs;
    phase_e            ph;
    logic [3:0]        bit_idx;
    logic [15:0]       ticks_left;
    logic              mode_pending;
    logic [LEVEL_W-1:0] lvl_held;
    logic              pin_lvl;
    out_t              line_state_q[$];
    int unsigned       fails;

    function new();
      regs.short_time     = RST_SHORT;
      regs.long_time      = RST_LONG;
      regs.mode_high_time = RST_MODE_HIGH;
      regs.mode_low_time  = RST_MODE_LOW;
      regs.settle_time    = RST_SETTLE;
      regs.device_address = RST_ADDRESS;
      ph           = PH_IDLE;
      bit_idx      = '0;
      ticks_left   = '0;
      mode_pending = 1'b0;
      lvl_held     = '0;
      pin_lvl      = 1'b0;
      fails        = 0;
    endfunction

    function void set_regs(cfg_t c);
      regs = c;
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int unsigned pending();
      return line_state_q.size();
    endfunction

    function void flag(string msg);
      fails++;
      if (fails <= 10) $display("mismatch: %s", msg);
    endfunction

    // Bit being sent: address MSB first, then three zeros and the level
    function logic cur_bit();
      if (ph == PH_ADDR_LOW || ph == PH_ADDR_HIGH)
        return regs.device_address[7 - int'(bit_idx)];
      if (bit_idx < 4'd3) return 1'b0;
      return lvl_held[LEVEL_W + 2 - int'(bit_idx)];
    endfunction

    function logic seg_level();
      case (ph)
        PH_MODE_HIGH, PH_MODE_SETTLE, PH_START_A, PH_ADDR_HIGH,
        PH_START_B, PH_DATA_HIGH, PH_FINAL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic [15:0] seg_ticks();
      case (ph)
        PH_OFF_SETTLE, PH_MODE_SETTLE, PH_FINAL: return regs.settle_time;
        PH_MODE_HIGH: return 16'(regs.mode_high_time);
        PH_MODE_LOW:  return 16'(regs.mode_low_time);
        PH_ADDR_LOW, PH_DATA_LOW:
          return cur_bit() ? 16'(regs.short_time) : 16'(regs.long_time);
        PH_ADDR_HIGH, PH_DATA_HIGH:
          return cur_bit() ? 16'(regs.long_time) : 16'(regs.short_time);
        default: return 16'(regs.long_time);
      endcase
    endfunction

    function void step_phase();
      case (ph)
        PH_MODE_HIGH:   ph = PH_MODE_LOW;
        PH_MODE_LOW:    ph = PH_MODE_SETTLE;
        PH_MODE_SETTLE: ph = PH_START_A;
        PH_START_A: begin
          ph = PH_ADDR_LOW;
          bit_idx = '0;
        end
        PH_ADDR_LOW:    ph = PH_ADDR_HIGH;
        PH_ADDR_HIGH: begin
          if (bit_idx >= 4'd7) ph = PH_EOS_A;
          else begin
            bit_idx++;
            ph = PH_ADDR_LOW;
          end
        end
        PH_EOS_A:       ph = PH_EOS_B;
        PH_EOS_B:       ph = PH_START_B;
        PH_START_B: begin
          ph = PH_DATA_LOW;
          bit_idx = '0;
        end
        PH_DATA_LOW:    ph = PH_DATA_HIGH;
        PH_DATA_HIGH: begin
          if (bit_idx >= 4'(2 + LEVEL_W)) ph = PH_EOS_C;
          else begin
            bit_idx++;
            ph = PH_DATA_LOW;
          end
        end
        PH_EOS_C:       ph = PH_FINAL;
        default:        ph = PH_IDLE;
      endcase
    endfunction

    // Enter the current segment; zero-length segments are passed over
    function void load_segment();
      logic [15:0] len;
      while (ph != PH_IDLE) begin
        len = seg_ticks();
        pin_lvl = seg_level();
        if (len != '0) begin
          ticks_left = len;
          return;
        end
        step_phase();
      end
      ticks_left = '0;
    endfunction

    // Accepted input transfer: advance the waveform, queue the line state
    function void note_input(in_t item);
      out_t res;
      res = '0;
      if (item.kind == KIND_LEVEL) begin
        if (ph != PH_IDLE) begin
          res.rejected = 1'b1;
        end else begin
          if (item.level == '0) begin
            mode_pending = 1'b1;
            ph = PH_OFF_SETTLE;
          end else begin
            lvl_held = item.level;
            ph = mode_pending ? PH_MODE_HIGH : PH_START_A;
            mode_pending = 1'b0;
          end
          bit_idx = '0;
          load_segment();
        end
      end else if (ph != PH_IDLE) begin
        ticks_left = ticks_left - 16'd1;
        if (ticks_left == '0) begin
          step_phase();
          load_segment();
        end
      end
      res.pin = pin_lvl;
      res.busy_res = (ph != PH_IDLE);
      line_state_q.push_back(res);
    endfunction

    // Output transfer against the oldest pending line state
    function void check_result(out_t got);
      out_t want;
      if (line_state_q.size() == 0) begin
        flag($sformatf("result with nothing pending: pin %0b busy %0b rej %0b",
                       got.pin, got.busy_res, got.rejected));
        return;
      end
      want = line_state_q.pop_front();
      if (got.pin !== want.pin || got.busy_res !== want.busy_res ||
          got.rejected !== want.rejected)
        flag($sformatf("pin exp %0b got %0b, busy exp %0b got %0b, rej exp %0b got %0b",
                       want.pin, got.pin, want.busy_res, got.busy_res,
                       want.rejected, got.rejected));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_pay    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_pay;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  dimming_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  bit          hold_started  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  single_wire_dimming_tx uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_pay),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_pay),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_single_wire_dimming_tx: FAIL");
      $finish;
    end
  end

  // Output side: check each transfer, stall at random or for one long hold
  always @(posedge clk) begin
    if (out_valid === 1'b1 && !out_stall) sb.check_result(out_pay);
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = 64;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic kind, input logic [LEVEL_W-1:0] lvl);
    in_t item;
    item.kind = kind;
    item.level = lvl;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pay <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
  endtask

  // Tick until the waveform has ended
  task automatic drain_wave();
    while (sb.busy()) send_item(KIND_TICK, LEVEL_W'($urandom_range(31)));
  endtask

  // Stop sending and let every pending result come out
  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input cfg_t c);
    reg_idx_e r;
    cfg_we <= 1'b1;
    for (int i = REG_SHORT; i <= REG_ADDRESS; i++) begin
      r = reg_idx_e'(i);
      cfg_idx <= r;
      case (r)
        REG_SHORT:     cfg_data <= 16'(c.short_time);
        REG_LONG:      cfg_data <= 16'(c.long_time);
        REG_MODE_HIGH: cfg_data <= 16'(c.mode_high_time);
        REG_MODE_LOW:  cfg_data <= 16'(c.mode_low_time);
        REG_SETTLE:    cfg_data <= c.settle_time;
        default:       cfg_data <= 16'(c.device_address);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_regs(c);
  endtask

  // Mostly complete command sequences; some idle ticks and busy commands
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned r;
    logic [LEVEL_W-1:0] lvl;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      lvl = LEVEL_W'($urandom_range(31));
      if (sb.busy()) begin
        send_item((r < 4) ? KIND_LEVEL : KIND_TICK, lvl);
        sent++;
      end else if (r < 10) begin
        send_item(KIND_TICK, lvl);
      end else begin
        if (r < 35) lvl = '0;
        send_item(KIND_LEVEL, lvl);
        sent++;
      end
    end
    drain_wave();
  endtask

  function automatic cfg_t make_regs(int unsigned st, int unsigned lt, int unsigned mh,
                                     int unsigned ml, int unsigned se, int unsigned ad);
    cfg_t c;
    c.short_time     = 8'(st);
    c.long_time      = 8'(lt);
    c.mode_high_time = 10'(mh);
    c.mode_low_time  = 10'(ml);
    c.settle_time    = 16'(se);
    c.device_address = 8'(ad);
    return c;
  endfunction

  initial begin
    int unsigned n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all frame segments of zero length, one-tick settle
    send_idle_pct = 24;
    recv_idle_pct = 71;
    write_regs(make_regs(0, 0, 2, 1, 1, 8'hA5));
    send_item(KIND_TICK, 5'h1F);    // tick while idle
    send_item(KIND_LEVEL, 5'h00);   // off
    send_item(KIND_LEVEL, 5'h09);   // command while busy
    drain_wave();
    send_item(KIND_TICK, 5'h00);
    send_item(KIND_LEVEL, 5'h1F);   // mode entry, then an empty frame
    send_item(KIND_LEVEL, 5'h00);   // command while busy
    drain_wave();
    send_item(KIND_LEVEL, 5'h01);   // no mode entry this time
    drain_wave();
    send_item(KIND_LEVEL, 5'h10);
    drain_wave();
    quiesce();

    // Random with short bit cells
    write_regs(make_regs(1, 3, 3, 2, 4, $urandom_range(255)));
    run_random(370);
    quiesce();

    send_idle_pct = 71;
    recv_idle_pct = 24;
    write_regs(make_regs($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                         $urandom_range(1, 4), $urandom_range(0, 5), $urandom_range(255)));
    run_random(370);
    quiesce();

    // No idling; zero-length segments likely; long output hold at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(make_regs($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(255)));
    hold_req = 1'b1;
    run_random(370);
    quiesce();

    // Shortest settings, no settle wait
    write_regs(make_regs(1, 1, 1, 1, 0, 8'h00));
    run_random(60);
    quiesce();

    // Largest register values: long settle after off, command while busy
    write_regs(make_regs(255, 255, 1023, 1023, 65535, 8'hFF));
    send_item(KIND_LEVEL, 5'h00);
    send_item(KIND_LEVEL, 5'h1F);
    repeat (24) send_item(KIND_TICK, LEVEL_W'($urandom_range(31)));

    // Wait out the remaining results, then check for leftovers
    in_valid <= 1'b0;
    for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fails == 0) $display("tb_single_wire_dimming_tx: PASS");
    else $display("tb_single_wire_dimming_tx: FAIL");
    $finish;
  end

endmodule

// ----- single_wire_dimming_tx.f -----
sv/swd_pkg.sv
sv/swd_front.sv
sv/swd_back.sv
sv/single_wire_dimming_tx.sv
verif/tb_single_wire_dimming_tx.sv
